/* rtl/yhdd_pkg.sv */
// Shared types and constants for the yaw hold differential drive unit.
package yhdd_pkg;

  localparam int unsigned CmdW   = 11;
  localparam int unsigned DeltaW = 12;
  localparam int unsigned MixW   = 13;
  localparam int unsigned QuotW  = 11;

  localparam logic [QuotW-1:0] QuotSat = 11'd1024;

  localparam logic signed [16:0] WrapHalf = 17'sd18000;
  localparam logic signed [16:0] WrapFull = 17'sd36000;

  localparam logic [2:0] RegTargetHeading = 3'd0;
  localparam logic [2:0] RegRunTimeMs     = 3'd1;
  localparam logic [2:0] RegBaseDrive     = 3'd2;
  localparam logic [2:0] RegGoReverse     = 3'd3;
  localparam logic [2:0] RegGainStraight  = 3'd4;
  localparam logic [2:0] RegGainTurn      = 3'd5;
  localparam logic [2:0] RegDeltaUpper    = 3'd6;
  localparam logic [2:0] RegDeltaLower    = 3'd7;

  localparam logic [9:0]         BaseDriveReset  = 10'd300;
  localparam logic [15:0]        GainReset       = 16'd100;
  localparam logic signed [10:0] DeltaUpperReset = 11'sd500;
  localparam logic signed [10:0] DeltaLowerReset = -11'sd500;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_START = 2'd1,
    OP_STOP  = 2'd2
  } opcode_e;

  typedef enum logic [1:0] {
    ACT_KEEP    = 2'd0,
    ACT_HALT    = 2'd1,
    ACT_CONTROL = 2'd2
  } action_e;

  typedef struct packed {
    logic signed [15:0] target_heading;
    logic [31:0]        run_time_ms;
    logic [9:0]         base_drive;
    logic               go_reverse;
    logic [15:0]        gain_straight;
    logic [15:0]        gain_turn;
    logic signed [10:0] delta_upper;
    logic signed [10:0] delta_lower;
  } cfg_t;

  typedef struct packed {
    action_e            act;
    logic               fresh;
    logic               moving;
    logic signed [15:0] err;
    logic               neg;
  } item_t;

endpackage

/* rtl/yaw_hold_differential_drive_unit.sv */
// Top level of the yaw hold differential drive unit.
// Each accepted beat yields exactly one result beat. It passes through registers a_q, b_q, c_q
// and d_q into the output register, and a new beat can be taken every cycle unless m_axis_tready
// holds the output back. The correction pipeline computes the error magnitude times gain,
// the constant scale, and the reciprocal multiply that divides by
// the per mille denominator, each behind its own register. Start, stop, timeout and yaw hold
// take effect at the accepted beat; the drive commands and heading error are committed in beat
// order as results enter the output register, which holds a result while the next beats move in.
module yaw_hold_differential_drive_unit #(
  parameter int PWM_FLOOR = -1000,
  parameter int PWM_CEIL  = 1000,
  parameter int SCALE_NUM = 1,
  parameter int SCALE_DEN = 1,
  parameter int TICK_MS   = 1,
  parameter int BASE_CAP  = 1000
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,  // now_tick, yaw_sample
  input  logic [2:0]  s_axis_tuser,  // opcode, yaw_ok
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,  // moving, heading_error, left_drive, right_drive,
                                     // left_backward, right_backward, left_magnitude,
                                     // right_magnitude, zero fill
  output logic [0:0]  m_axis_tuser   // sample_fresh
);

  localparam int DIV     = 1000 * SCALE_DEN;
  localparam int SAT_LIM = 1024 * DIV;
  localparam int XW      = $clog2(SAT_LIM);
  localparam int LW      = $clog2(DIV);
  localparam int SH      = XW + LW;
  localparam int RW      = XW + 1;
  localparam int PW      = XW + RW;
  localparam int SNW     = $clog2(SCALE_NUM + 1);
  localparam int M2W     = 32 + SNW;
  localparam logic [RW-1:0] RECIP =
      RW'(((64'd1 << SH) + 64'(DIV) - 64'd1) / 64'(DIV));

  yhdd_pkg::cfg_t cfg_q;

  logic               run_q, run_d;
  logic [31:0]        start_q, start_d;
  logic signed [15:0] held_q, held_d;
  logic signed [yhdd_pkg::CmdW-1:0] cmd_l_q, cmd_l_d;
  logic signed [yhdd_pkg::CmdW-1:0] cmd_r_q, cmd_r_d;
  logic signed [15:0] last_err_q, last_err_d;

  logic        va_q, vb_q, vc_q, vd_q, vo_q;
  logic        go_a, go_b, go_c, go_d, go_o;
  logic        accept;

  yhdd_pkg::item_t item_d, a_q, b_q, c_q, d_q;
  logic [31:0]     b_prod_q;
  logic            c_sat_q, d_sat_q;
  logic [XW-1:0]   c_x_q;
  logic [PW-1:0]   d_prod_q;

  logic [31:0]        elapsed;
  logic signed [16:0] err_raw;
  logic signed [16:0] err_wrap;
  logic [15:0]        err_mag;
  logic [15:0]        gain;
  logic [M2W-1:0]     scaled;
  logic [yhdd_pkg::QuotW-1:0]         quot;
  logic signed [yhdd_pkg::DeltaW-1:0] delta;
  logic signed [yhdd_pkg::CmdW-1:0]   mix_l, mix_r;

  logic       straight;
  logic       lb, rb;
  logic [9:0] lm, rm;
  logic [63:0] out_data_q;
  logic        out_fresh_q;

  logic [9:0] base_wr;

  assign base_wr = (cfg_data_i[9:0] > 10'(BASE_CAP)) ? 10'(BASE_CAP) : cfg_data_i[9:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.target_heading <= '0;
      cfg_q.run_time_ms    <= '0;
      cfg_q.base_drive     <= yhdd_pkg::BaseDriveReset;
      cfg_q.go_reverse     <= 1'b0;
      cfg_q.gain_straight  <= yhdd_pkg::GainReset;
      cfg_q.gain_turn      <= yhdd_pkg::GainReset;
      cfg_q.delta_upper    <= yhdd_pkg::DeltaUpperReset;
      cfg_q.delta_lower    <= yhdd_pkg::DeltaLowerReset;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        yhdd_pkg::RegTargetHeading: cfg_q.target_heading <= $signed(cfg_data_i[15:0]);
        yhdd_pkg::RegRunTimeMs:     cfg_q.run_time_ms    <= cfg_data_i;
        yhdd_pkg::RegBaseDrive:     cfg_q.base_drive     <= base_wr;
        yhdd_pkg::RegGoReverse:     cfg_q.go_reverse     <= cfg_data_i[0];
        yhdd_pkg::RegGainStraight:  cfg_q.gain_straight  <= cfg_data_i[15:0];
        yhdd_pkg::RegGainTurn:      cfg_q.gain_turn      <= cfg_data_i[15:0];
        yhdd_pkg::RegDeltaUpper:    cfg_q.delta_upper    <= $signed(cfg_data_i[10:0]);
        yhdd_pkg::RegDeltaLower:    cfg_q.delta_lower    <= $signed(cfg_data_i[10:0]);
        default: ;
      endcase
    end
  end

  assign go_o   = !vo_q || m_axis_tready;
  assign go_d   = !vd_q || go_o;
  assign go_c   = !vc_q || go_d;
  assign go_b   = !vb_q || go_c;
  assign go_a   = !va_q || go_b;
  assign accept = s_axis_tvalid && go_a;
  assign s_axis_tready = go_a;

  always_comb begin
    item_d.act    = yhdd_pkg::ACT_KEEP;
    item_d.fresh  = 1'b0;
    run_d         = run_q;
    start_d       = start_q;
    held_d        = held_q;
    elapsed       = 32'((s_axis_tdata[31:0] - start_q) * 32'(TICK_MS));
    unique case (s_axis_tuser[1:0])
      yhdd_pkg::OP_START: begin
        start_d = s_axis_tdata[31:0];
        run_d   = 1'b1;
      end
      yhdd_pkg::OP_STOP: begin
        item_d.act = yhdd_pkg::ACT_HALT;
        run_d      = 1'b0;
      end
      yhdd_pkg::OP_TICK: begin
        if (run_q) begin
          if (s_axis_tuser[2]) held_d = $signed(s_axis_tdata[47:32]);
          item_d.fresh = s_axis_tuser[2];
          if (elapsed >= cfg_q.run_time_ms) begin
            item_d.act = yhdd_pkg::ACT_HALT;
            run_d      = 1'b0;
          end else begin
            item_d.act = yhdd_pkg::ACT_CONTROL;
          end
        end
      end
      default: ;
    endcase
    err_raw = 17'(cfg_q.target_heading) - 17'(held_d);
    priority if (err_raw > yhdd_pkg::WrapHalf) begin
      err_wrap = err_raw - yhdd_pkg::WrapFull;
    end else if (err_raw < -yhdd_pkg::WrapHalf) begin
      err_wrap = err_raw + yhdd_pkg::WrapFull;
    end else begin
      err_wrap = err_raw;
    end
    item_d.err    = err_wrap[15:0];
    item_d.neg    = err_wrap[16];
    item_d.moving = run_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q   <= 1'b0;
      start_q <= '0;
      held_q  <= '0;
    end else if (accept) begin
      run_q   <= run_d;
      start_q <= start_d;
      held_q  <= held_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
      vd_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      if (go_a) va_q <= s_axis_tvalid;
      if (go_b) vb_q <= va_q;
      if (go_c) vc_q <= vb_q;
      if (go_d) vd_q <= vc_q;
      if (go_o) vo_q <= vd_q;
    end
  end

  assign err_mag = a_q.neg ? 16'(-a_q.err) : a_q.err;
  assign gain    = (cfg_q.base_drive != '0) ? cfg_q.gain_straight : cfg_q.gain_turn;
  assign scaled  = M2W'(b_prod_q) * M2W'(SCALE_NUM);

  always_ff @(posedge clk_i) begin
    if (go_a) a_q <= item_d;
    if (go_b) begin
      b_q      <= a_q;
      b_prod_q <= 32'(err_mag) * 32'(gain);
    end
    if (go_c) begin
      c_q     <= b_q;
      c_sat_q <= scaled >= M2W'(SAT_LIM);
      c_x_q   <= scaled[XW-1:0];
    end
    if (go_d) begin
      d_q      <= c_q;
      d_sat_q  <= c_sat_q;
      d_prod_q <= PW'(c_x_q) * PW'(RECIP);
    end
  end

  assign quot  = d_sat_q ? yhdd_pkg::QuotSat : yhdd_pkg::QuotW'(d_prod_q >> SH);
  assign delta = d_q.neg ? -$signed({1'b0, quot}) : $signed({1'b0, quot});

  yhdd_mixer #(
    .PWM_FLOOR (PWM_FLOOR),
    .PWM_CEIL  (PWM_CEIL)
  ) u_mixer (
    .delta_i     (delta),
    .cfg_i       (cfg_q),
    .left_cmd_o  (mix_l),
    .right_cmd_o (mix_r)
  );

  always_comb begin
    cmd_l_d    = cmd_l_q;
    cmd_r_d    = cmd_r_q;
    last_err_d = last_err_q;
    unique case (d_q.act)
      yhdd_pkg::ACT_HALT: begin
        cmd_l_d = '0;
        cmd_r_d = '0;
      end
      yhdd_pkg::ACT_CONTROL: begin
        cmd_l_d    = mix_l;
        cmd_r_d    = mix_r;
        last_err_d = d_q.err;
      end
      default: ;
    endcase
    straight = d_q.moving && (cfg_q.base_drive != '0);
    if (straight) begin
      lb = cfg_q.go_reverse;
      rb = cfg_q.go_reverse;
      lm = cmd_l_d[yhdd_pkg::CmdW-1] ? '0 : cmd_l_d[9:0];
      rm = cmd_r_d[yhdd_pkg::CmdW-1] ? '0 : cmd_r_d[9:0];
    end else begin
      lb = cmd_l_d[yhdd_pkg::CmdW-1];
      rb = cmd_r_d[yhdd_pkg::CmdW-1];
      lm = lb ? 10'(-cmd_l_d) : cmd_l_d[9:0];
      rm = rb ? 10'(-cmd_r_d) : cmd_r_d[9:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_l_q    <= '0;
      cmd_r_q    <= '0;
      last_err_q <= '0;
    end else if (go_o && vd_q) begin
      cmd_l_q    <= cmd_l_d;
      cmd_r_q    <= cmd_r_d;
      last_err_q <= last_err_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (go_o && vd_q) begin
      out_data_q  <= {3'b000, rm, lm, rb, lb, cmd_r_d, cmd_l_d, last_err_d, d_q.moving};
      out_fresh_q <= d_q.fresh;
    end
  end

  assign m_axis_tvalid   = vo_q;
  assign m_axis_tdata    = out_data_q;
  assign m_axis_tuser[0] = out_fresh_q;

endmodule

/* rtl/yhdd_mixer.sv */
// Correction clamp, drive mixing and PWM saturation for both wheels.
module yhdd_mixer #(
  parameter int PWM_FLOOR = -1000,
  parameter int PWM_CEIL  = 1000
) (
  input  logic signed [yhdd_pkg::DeltaW-1:0] delta_i,
  input  yhdd_pkg::cfg_t                     cfg_i,
  output logic signed [yhdd_pkg::CmdW-1:0]   left_cmd_o,
  output logic signed [yhdd_pkg::CmdW-1:0]   right_cmd_o
);

  localparam logic signed [yhdd_pkg::MixW-1:0] Floor = yhdd_pkg::MixW'(PWM_FLOOR);
  localparam logic signed [yhdd_pkg::MixW-1:0] Ceil  = yhdd_pkg::MixW'(PWM_CEIL);

  logic signed [yhdd_pkg::DeltaW-1:0] upper;
  logic signed [yhdd_pkg::DeltaW-1:0] lower;
  logic signed [yhdd_pkg::DeltaW-1:0] d;
  logic signed [yhdd_pkg::MixW-1:0]   d_ext;
  logic signed [yhdd_pkg::MixW-1:0]   base;
  logic signed [yhdd_pkg::MixW-1:0]   l;
  logic signed [yhdd_pkg::MixW-1:0]   r;
  logic signed [yhdd_pkg::MixW-1:0]   l_sat;
  logic signed [yhdd_pkg::MixW-1:0]   r_sat;

  always_comb begin
    upper = yhdd_pkg::DeltaW'(cfg_i.delta_upper);
    lower = yhdd_pkg::DeltaW'(cfg_i.delta_lower);
    priority if (delta_i > upper) begin
      d = upper;
    end else if (delta_i < lower) begin
      d = lower;
    end else begin
      d = delta_i;
    end
    d_ext = yhdd_pkg::MixW'(d);
    base  = $signed({3'b000, cfg_i.base_drive});
    if (cfg_i.base_drive != '0) begin
      l = base - d_ext;
      r = base + d_ext;
      if (l < 0) l = '0;
      if (r < 0) r = '0;
    end else begin
      l = -d_ext;
      r = d_ext;
    end
    priority if (l < Floor) begin
      l_sat = Floor;
    end else if (l > Ceil) begin
      l_sat = Ceil;
    end else begin
      l_sat = l;
    end
    priority if (r < Floor) begin
      r_sat = Floor;
    end else if (r > Ceil) begin
      r_sat = Ceil;
    end else begin
      r_sat = r;
    end
  end

  assign left_cmd_o  = l_sat[yhdd_pkg::CmdW-1:0];
  assign right_cmd_o = r_sat[yhdd_pkg::CmdW-1:0];

endmodule
